### design/mhf_pkg.sv
// shared types, constants and angle table for the magnetometer heading filter
package mhf_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 16;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);
    localparam int ANGLE_IDX_W   = 5;
    localparam int Z_W           = 18;
    localparam int GAIN_W        = 16;
    localparam int ACC_W         = 32;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd655;
    localparam logic signed [Z_W-1:0] HALF_TURN = 18'sd23040;
    localparam logic signed [Z_W-1:0] FULL_TURN = 18'sd46080;
    localparam logic REG_GAIN = 1'b0;

    typedef struct packed {
        logic [7:0] x_high;
        logic [7:0] x_low;
        logic [7:0] z_high;
        logic [7:0] z_low;
        logic [7:0] y_high;
        logic [7:0] y_low;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] smooth_x;
        logic signed [15:0] smooth_y;
        logic [15:0]        heading;
    } out_word_t;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic              acc;
        logic              init;
        logic              iter;
        logic              finish;
        logic [STEP_W-1:0] step;
    } cmd_t;

    function automatic logic signed [Z_W-1:0] angle_q7(input logic [ANGLE_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            5'd0:    a = 18'sd5760;
            5'd1:    a = 18'sd3400;
            5'd2:    a = 18'sd1797;
            5'd3:    a = 18'sd912;
            5'd4:    a = 18'sd458;
            5'd5:    a = 18'sd229;
            5'd6:    a = 18'sd115;
            5'd7:    a = 18'sd57;
            5'd8:    a = 18'sd29;
            5'd9:    a = 18'sd14;
            5'd10:   a = 18'sd7;
            5'd11:   a = 18'sd4;
            5'd12:   a = 18'sd2;
            5'd13:   a = 18'sd1;
            default: a = 18'sd0;
        endcase
        return a;
    endfunction

endpackage

### design/mhf_ctrl.sv
// sequencing state machine for the heading filter: filter update then cordic steps
module mhf_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          out_full,
    output mhf_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_INIT = 3'd3;
    localparam logic [2:0] ST_ITER = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [mhf_pkg::STEP_W-1:0] LAST_STEP =
        mhf_pkg::STEP_W'(mhf_pkg::CORDIC_STEPS - 1);

    logic [2:0]                  state_reg, state_next;
    logic [mhf_pkg::STEP_W-1:0]  step_reg, step_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.iter  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL))
        else $error("accepted word did not start the filter update");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (step_reg <= LAST_STEP))
        else $error("cordic step count out of range");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_full)
        else $error("result written while output word still stalled");

endmodule

### design/mhf_datapath.sv
// filter accumulators, the X and Y gain multipliers and the iterative cordic unit
module mhf_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mhf_pkg::cmd_t                 cmd,
    input  mhf_pkg::in_word_t             in_data,
    input  logic [mhf_pkg::GAIN_W-1:0]    gain,
    output mhf_pkg::out_word_t            result
);

    localparam int RAW_W = 16 + mhf_pkg::FRACTION_BITS;
    localparam int D_W   = ((RAW_W > mhf_pkg::ACC_W) ? RAW_W : mhf_pkg::ACC_W) + 1;
    localparam int P_W   = D_W + mhf_pkg::GAIN_W + 1;
    localparam int S_W   = P_W - 16 + 1;
    localparam int X_W   = mhf_pkg::ACC_W + 4;
    localparam int ACC_W = mhf_pkg::ACC_W;
    localparam int Z_W   = mhf_pkg::Z_W;

    logic signed [15:0]    raw_x_reg, raw_y_reg;
    logic signed [ACC_W-1:0] fx_reg, fy_reg, fx_next, fy_next;
    logic signed [P_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [X_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0] z_reg;
    logic                  zero_reg;

    logic signed [D_W-1:0] d_x, d_y;
    logic signed [mhf_pkg::GAIN_W:0] gain_s;
    logic signed [X_W-1:0] init_x, init_y, sh_x, sh_y;
    logic signed [Z_W-1:0] ang, h;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [S_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if ((&v[S_W-1:ACC_W-1]) || !(|v[S_W-1:ACC_W-1]))
            r = v[ACC_W-1:0];
        else
            r = {v[S_W-1], {(ACC_W-1){~v[S_W-1]}}};
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] filter_step(
        input logic signed [ACC_W-1:0] f,
        input logic signed [P_W-1:0]   p
    );
        logic signed [P_W-1:0] rounded;
        logic signed [S_W-1:0] sum;
        rounded = p + P_W'(32768);
        sum = S_W'(f) + S_W'(rounded >>> 16);
        return sat_acc(sum);
    endfunction

    function automatic logic signed [15:0] int_part(input logic signed [ACC_W-1:0] f);
        logic signed [ACC_W-1:0] s;
        logic signed [15:0] r;
        s = f >>> mhf_pkg::FRACTION_BITS;
        if ((&s[ACC_W-1:15]) || !(|s[ACC_W-1:15]))
            r = s[15:0];
        else
            r = {s[ACC_W-1], {15{~s[ACC_W-1]}}};
        return r;
    endfunction

    assign gain_s = $signed({1'b0, gain});
    assign d_x = (D_W'(raw_x_reg) <<< mhf_pkg::FRACTION_BITS) - D_W'(fx_reg);
    assign d_y = (D_W'(raw_y_reg) <<< mhf_pkg::FRACTION_BITS) - D_W'(fy_reg);
    assign fx_next = filter_step(fx_reg, prod_x_reg);
    assign fy_next = filter_step(fy_reg, prod_y_reg);

    // the vector is (filtered y, filtered x)
    assign init_x = X_W'(fy_reg);
    assign init_y = X_W'(fx_reg);
    assign sh_x   = x_reg >>> cmd.step;
    assign sh_y   = y_reg >>> cmd.step;
    assign ang    = mhf_pkg::angle_q7(mhf_pkg::ANGLE_IDX_W'(cmd.step));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= '0;
            fy_reg <= '0;
        end
        else if (cmd.acc)
        begin
            fx_reg <= fx_next;
            fy_reg <= fy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_x_reg <= $signed({in_data.x_high, in_data.x_low});
            raw_y_reg <= $signed({in_data.y_high, in_data.y_low});
        end
        if (cmd.mul)
        begin
            prod_x_reg <= P_W'(d_x) * P_W'(gain_s);
            prod_y_reg <= P_W'(d_y) * P_W'(gain_s);
        end
        if (cmd.init)
        begin
            zero_reg <= (fx_reg == '0) && (fy_reg == '0);
            if (init_x < 0)
            begin
                x_reg <= -init_x;
                y_reg <= -init_y;
                z_reg <= (init_y >= 0) ? mhf_pkg::HALF_TURN : -mhf_pkg::HALF_TURN;
            end
            else
            begin
                x_reg <= init_x;
                y_reg <= init_y;
                z_reg <= '0;
            end
        end
        else if (cmd.iter)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + sh_y;
                y_reg <= y_reg - sh_x;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - sh_y;
                y_reg <= y_reg + sh_x;
                z_reg <= z_reg - ang;
            end
        end
    end

    assign h = z_reg + mhf_pkg::HALF_TURN;

    always_comb
    begin
        result.smooth_x = int_part(fx_reg);
        result.smooth_y = int_part(fy_reg);
        if (zero_reg)
            result.heading = 16'(mhf_pkg::HALF_TURN);
        else if (h < 0)
            result.heading = '0;
        else if (h > mhf_pkg::FULL_TURN)
            result.heading = 16'(mhf_pkg::FULL_TURN);
        else
            result.heading = h[15:0];
    end

    a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.iter |-> !x_reg[X_W-1])
        else $error("cordic x went negative");

endmodule

### design/magnetometer_heading_filter.sv
// top level of the magnetometer heading filter: register port, output word, control and datapath
// Usage:
// - input channel in_valid/in_stall/in_data carries one sample word: the six data
//   register bytes X high, X low, Z high, Z low, Y high, Y low (Z is ignored)
// - output channel out_valid/out_stall/out_data returns one word per sample: the
//   integer parts of the smoothed X and Y and the heading in Q9.7 degrees, 0 to 360
// - register 0 at byte address 0 holds the smoothing gain (Q0.16), reset value 655;
//   write it only while no sample is in flight
// - a sample runs from acceptance to the output word through the filter update in the
//   gain multipliers and accumulators, a set-up step and the 16 steps of the cordic
//   loop, then the output register load, which waits while the output word is stalled
// - one sample at a time: in_stall is high from acceptance until the result is
//   loaded, so a new sample is taken only once the previous result is loaded
// - when the receiver stalls, the finished word waits in the output register; a
//   next sample is still taken and runs, and only its final load waits for room
// - reset clears both filters to zero, restores the gain and empties the output
module magnetometer_heading_filter
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  mhf_pkg::in_word_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output mhf_pkg::out_word_t             out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [mhf_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic                       out_valid_reg, out_valid_next;
    mhf_pkg::out_word_t         out_data_reg;
    mhf_pkg::out_word_t         result;
    mhf_pkg::cmd_t              cmd;
    logic                       out_full;
    logic                       wr_gain;

    assign pready   = 1'b1;
    assign wr_gain  = psel && penable && pwrite && (paddr[2] == mhf_pkg::REG_GAIN);
    assign gain_next = wr_gain ? pwdata[mhf_pkg::GAIN_W-1:0] : gain_reg;
    assign prdata   = (paddr[2] == mhf_pkg::REG_GAIN) ? 32'(gain_reg) : '0;

    assign out_full  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= mhf_pkg::GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_data_reg <= result;
    end

    mhf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_full (out_full),
        .cmd      (cmd)
    );

    mhf_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_data (in_data),
        .gain    (gain_reg),
        .result  (result)
    );

    a_stalled_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled output word changed");

endmodule
